/* hw/rtl/pebrp_pkg.sv */
package pebrp_pkg;

    localparam int unsigned WORD_W  = 16;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned LEFT_W  = 31;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W   = 2;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned TDATA_W = 72;

    localparam logic [31:0] HEADER_BYTES = 32'd8;
    localparam logic [31:0] MIN_BLOCK_BYTES = 32'd10;
    localparam logic [3:0]  TYPE_HIGHADJ = 4'd4;

    // result kinds
    localparam logic [1:0] KIND_ENTRY = 2'd0;
    localparam logic [1:0] KIND_PARAM = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_ADDRESS  = 2'd1;
    localparam logic [1:0] ERR_LENGTH   = 2'd2;
    localparam logic [1:0] ERR_BAD_TYPE = 2'd3;

    // register indexes (byte address bit 2)
    localparam logic REG_IMAGE_SIZE = 1'b0;
    localparam logic REG_DIR_SIZE   = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] block_address;
        logic [3:0]  entry_type;
        logic [11:0] entry_offset;
        logic [15:0] raw_word;
        logic        type_bad;
        logic        block_last;
        logic [1:0]  error_code;
        logic        last;
    } result_t;

    function automatic logic type_allowed(input logic [3:0] t);
        return (t <= 4'd5) || (t == 4'd9) || (t == 4'd10);
    endfunction

endpackage

/* hw/rtl/pe_base_relocation_parser_unit.sv */
// relocation directory parser
// s_ channel: one directory halfword per item, s_tdata = word, s_tuser = first
// (first clears the parser before the word is handled)
// m_ channel: entry, highadj parameter, empty block and end-of-directory items;
// header words yield none but an empty block or end item, the final word of a block may yield two
// apb port: image_size at 0x0, directory_size at 0x4, write only while idle
// an item waits in the input register until the queue has room; its results are
// written into a 4-deep result queue and show on m_ from the queue head
// throughput: one item per cycle while each item yields at most one result and
// m_tready stays high; the result queue takes up to two results at once but
// drains one result per cycle
// input side runs while the queue holds two free slots, so s_tready never
// depends on m_tready combinationally; a stalled receiver lets the queue fill
// until fewer than two slots are free and then holds s_tready low
// reset: parser state, queue and both registers cleared, no item pending
// after a header error or the end of the directory, words give no result
// until an item with first set
module pe_base_relocation_parser_unit
    import pebrp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // directory halfwords
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // word
    input  logic                 s_tuser,   // first
    // results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // block_address[31:0], entry_type[35:32], entry_offset[47:36], raw_word[63:48],
    // type_bad[64], block_last[65], error_code[67:66], zero[71:68]
    output logic [TDATA_W-1:0]   m_tdata,
    output logic [1:0]           m_tuser,   // kind
    output logic                 m_tlast    // last result of its item
);

    // configuration registers
    logic [31:0] image_size_reg;
    logic [31:0] dir_size_reg;

    // input register
    logic              in_valid_reg;
    logic [WORD_W-1:0] in_word_reg;
    logic              in_first_reg;

    // parser state
    logic [31:0]       pos_reg,       pos_next;
    logic [31:0]       haddr_reg,     haddr_next;
    logic [31:0]       hsize_reg,     hsize_next;
    logic [1:0]        hidx_reg,      hidx_next;
    logic [LEFT_W-1:0] left_reg,      left_next;
    logic              in_ent_reg,    in_ent_next;
    logic              param_reg,     param_next;
    logic [1:0]        err_reg,       err_next;
    logic              stopped_reg,   stopped_next;

    // result queue
    result_t           fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    logic    advance;
    logic    accept_in;
    logic    pop;
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;

    // state as seen by the current item (first clears it)
    logic [31:0]       eff_pos;
    logic [31:0]       eff_haddr;
    logic [31:0]       eff_hsize;
    logic [1:0]        eff_hidx;
    logic [LEFT_W-1:0] eff_left;
    logic              eff_in_ent;
    logic              eff_param;
    logic [1:0]        eff_err;
    logic              eff_stopped;

    logic [31:0]       pos_plus2;
    logic              end_here;
    logic              end_after;
    logic [3:0]        w_type;
    logic              w_bad;
    logic [LEFT_W-1:0] left_m1;
    logic [31:0]       full_size;
    logic [31:0]       blk_start;
    logic [32:0]       blk_end;
    logic [31:0]       size_less_hdr;
    logic [1:0]        err_with_type;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_IMAGE_SIZE: prdata = image_size_reg;
            REG_DIR_SIZE:   prdata = dir_size_reg;
            default:        prdata = image_size_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_size_reg <= '0;
            dir_size_reg   <= '0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_DIR_SIZE) begin
                dir_size_reg <= pwdata;
            end else begin
                image_size_reg <= pwdata;
            end
        end
    end

    // ---------------- input register ----------------
    // item moves on when the queue can take two results
    assign advance   = in_valid_reg && (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign s_tready  = !in_valid_reg || advance;
    assign accept_in = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (accept_in) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_in) begin
            in_word_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
    end

    // ---------------- parser step ----------------
    assign eff_pos     = in_first_reg ? '0 : pos_reg;
    assign eff_haddr   = in_first_reg ? '0 : haddr_reg;
    assign eff_hsize   = in_first_reg ? '0 : hsize_reg;
    assign eff_hidx    = in_first_reg ? '0 : hidx_reg;
    assign eff_left    = in_first_reg ? '0 : left_reg;
    assign eff_in_ent  = in_first_reg ? 1'b0 : in_ent_reg;
    assign eff_param   = in_first_reg ? 1'b0 : param_reg;
    assign eff_err     = in_first_reg ? ERR_NONE : err_reg;
    assign eff_stopped = in_first_reg ? 1'b0 : stopped_reg;

    assign pos_plus2 = eff_pos + 32'd2;
    // no further header fits
    assign end_here  = ({1'b0, eff_pos} + {1'b0, HEADER_BYTES}) >= {1'b0, dir_size_reg};
    assign end_after = ({1'b0, pos_plus2} + {1'b0, HEADER_BYTES}) >= {1'b0, dir_size_reg};

    assign w_type  = in_word_reg[15:12];
    assign w_bad   = !type_allowed(w_type);
    assign left_m1 = eff_left - LEFT_W'(1);
    assign err_with_type = (eff_err == ERR_NONE && w_bad) ? ERR_BAD_TYPE : eff_err;

    // header completes on its fourth word
    assign full_size     = {in_word_reg, eff_hsize[15:0]};
    assign blk_start     = pos_plus2 - HEADER_BYTES;
    assign blk_end       = {1'b0, blk_start} + {1'b0, full_size};
    assign size_less_hdr = full_size - HEADER_BYTES;

    always_comb begin
        pos_next     = eff_pos;
        haddr_next   = eff_haddr;
        hsize_next   = eff_hsize;
        hidx_next    = eff_hidx;
        left_next    = eff_left;
        in_ent_next  = eff_in_ent;
        param_next   = eff_param;
        err_next     = eff_err;
        stopped_next = eff_stopped;

        push0 = 1'b0;
        push1 = 1'b0;

        res0 = '0;
        res0.block_address = eff_haddr;
        res0.error_code    = eff_err;
        res0.last          = 1'b1;
        res1 = '0;
        res1.kind          = KIND_END;
        res1.block_address = eff_haddr;
        res1.error_code    = eff_err;
        res1.last          = 1'b1;

        if (eff_stopped) begin
            // nothing until the next directory
        end else if (eff_in_ent) begin
            push0     = 1'b1;
            pos_next  = pos_plus2;
            left_next = left_m1;
            if (eff_param) begin
                param_next    = 1'b0;
                res0.kind     = KIND_PARAM;
                res0.raw_word = in_word_reg;
            end else begin
                err_next          = err_with_type;
                res0.kind         = KIND_ENTRY;
                res0.entry_type   = w_type;
                res0.entry_offset = in_word_reg[11:0];
                res0.raw_word     = in_word_reg;
                res0.type_bad     = w_bad;
                res0.error_code   = err_with_type;
                res1.error_code   = err_with_type;
                param_next        = (w_type == TYPE_HIGHADJ) && (eff_left > LEFT_W'(1));
            end
            if (left_m1 == '0) begin
                // final word of the block
                in_ent_next     = 1'b0;
                param_next      = 1'b0;
                res0.block_last = 1'b1;
                if (end_after) begin
                    stopped_next = 1'b1;
                    push1        = 1'b1;
                    res0.last    = 1'b0;
                end
            end
        end else begin
            unique case (eff_hidx)
                2'd0: begin
                    if (end_here) begin
                        stopped_next = 1'b1;
                        push0        = 1'b1;
                        res0.kind    = KIND_END;
                    end else begin
                        haddr_next = {16'd0, in_word_reg};
                        pos_next   = pos_plus2;
                        hidx_next  = 2'd1;
                    end
                end
                2'd1: begin
                    haddr_next = {in_word_reg, eff_haddr[15:0]};
                    pos_next   = pos_plus2;
                    hidx_next  = 2'd2;
                end
                2'd2: begin
                    hsize_next = {16'd0, in_word_reg};
                    pos_next   = pos_plus2;
                    hidx_next  = 2'd3;
                end
                default: begin
                    hsize_next = full_size;
                    pos_next   = pos_plus2;
                    hidx_next  = 2'd0;
                    priority if (eff_haddr > image_size_reg) begin
                        err_next        = (eff_err == ERR_NONE) ? ERR_ADDRESS : eff_err;
                        stopped_next    = 1'b1;
                        push0           = 1'b1;
                        res0.kind       = KIND_END;
                        res0.error_code = (eff_err == ERR_NONE) ? ERR_ADDRESS : eff_err;
                    end else if (blk_end > {1'b0, dir_size_reg}) begin
                        err_next        = (eff_err == ERR_NONE) ? ERR_LENGTH : eff_err;
                        stopped_next    = 1'b1;
                        push0           = 1'b1;
                        res0.kind       = KIND_END;
                        res0.error_code = (eff_err == ERR_NONE) ? ERR_LENGTH : eff_err;
                    end else if (full_size >= MIN_BLOCK_BYTES) begin
                        left_next   = size_less_hdr[31:1];
                        in_ent_next = 1'b1;
                        param_next  = 1'b0;
                    end else begin
                        // short block holds no entries
                        push0           = 1'b1;
                        res0.kind       = KIND_EMPTY;
                        res0.block_last = 1'b1;
                        if (end_after) begin
                            stopped_next = 1'b1;
                            push1        = 1'b1;
                            res0.last    = 1'b0;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            haddr_reg   <= '0;
            hsize_reg   <= '0;
            hidx_reg    <= '0;
            left_reg    <= '0;
            in_ent_reg  <= 1'b0;
            param_reg   <= 1'b0;
            err_reg     <= ERR_NONE;
            stopped_reg <= 1'b0;
        end else if (advance) begin
            pos_reg     <= pos_next;
            haddr_reg   <= haddr_next;
            hsize_reg   <= hsize_next;
            hidx_reg    <= hidx_next;
            left_reg    <= left_next;
            in_ent_reg  <= in_ent_next;
            param_reg   <= param_next;
            err_reg     <= err_next;
            stopped_reg <= stopped_next;
        end
    end

    // ---------------- result queue ----------------
    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (advance && push0) begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (advance && push1) begin
            fifo_mem[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (advance) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(push0) + PTR_W'(push1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg
                         + (advance ? (CNT_W'(push0) + CNT_W'(push1)) : CNT_W'(0))
                         - CNT_W'(pop);
        end
    end

    result_t head;
    assign head = fifo_mem[rd_ptr_reg];

    assign m_tdata = {4'd0, head.error_code, head.block_last, head.type_bad,
                      head.raw_word, head.entry_offset, head.entry_type,
                      head.block_address};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

/* bench/reloc_result_checker.sv */
module reloc_result_checker
    import pebrp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [15:0]        s_tdata,
    input  logic               s_tuser,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic [1:0]         m_tuser,
    input  logic               m_tlast,
    output int                 mismatches,
    output int                 outstanding
);

    // relocation types accepted without error
    localparam logic [3:0] LAST_PLAIN_TYPE = 4'd5;
    localparam logic [3:0] TYPE_IMM64      = 4'd9;
    localparam logic [3:0] TYPE_DIR64      = 4'd10;

    logic [31:0]       image_size_q;
    logic [31:0]       dir_size_q;
    logic [31:0]       byte_pos;
    logic [31:0]       hdr_address;
    logic [31:0]       hdr_size;
    logic [1:0]        hdr_index;
    logic [LEFT_W-1:0] entries_left;
    logic              in_entries;
    logic              param_pending;
    logic              stopped;
    logic [1:0]        first_error;
    result_t           expected_results[$];

    // no further header fits in the directory
    function automatic logic dir_exhausted();
        return ({1'b0, byte_pos} + 33'd8) >= {1'b0, dir_size_q};
    endfunction

    task automatic clear_parser();
        byte_pos      = '0;
        hdr_address   = '0;
        hdr_size      = '0;
        hdr_index     = '0;
        entries_left  = '0;
        in_entries    = 1'b0;
        param_pending = 1'b0;
        stopped       = 1'b0;
        first_error   = ERR_NONE;
    endtask

    task automatic queue_expected(input result_t r);
        expected_results = {expected_results, r};
    endtask

    task automatic push_end_of_dir();
        result_t r;
        r               = '0;
        r.kind          = KIND_END;
        r.block_address = hdr_address;
        r.error_code    = first_error;
        r.last          = 1'b1;
        stopped         = 1'b1;
        queue_expected(r);
    endtask

    // final result of a block, followed by the end item once the directory is used up
    task automatic close_block(input result_t r);
        if (dir_exhausted()) begin
            r.last = 1'b0;
            queue_expected(r);
            push_end_of_dir();
        end else begin
            r.last = 1'b1;
            queue_expected(r);
        end
    endtask

    task automatic predict_halfword(input logic [15:0] w, input logic first_flag);
        result_t     r;
        logic [3:0]  ty;
        logic        bad;
        logic [32:0] block_end;
        if (first_flag)
            clear_parser();
        if (stopped)
            return;
        r = '0;
        if (in_entries) begin
            r.block_address = hdr_address;
            r.raw_word      = w;
            if (param_pending) begin
                param_pending = 1'b0;
                r.kind        = KIND_PARAM;
            end else begin
                ty  = w[15:12];
                bad = !(ty <= LAST_PLAIN_TYPE || ty == TYPE_IMM64 || ty == TYPE_DIR64);
                if (bad && first_error == ERR_NONE)
                    first_error = ERR_BAD_TYPE;
                r.kind         = KIND_ENTRY;
                r.entry_type   = ty;
                r.entry_offset = w[11:0];
                r.type_bad     = bad;
                if (ty == TYPE_HIGHADJ && entries_left > LEFT_W'(1))
                    param_pending = 1'b1;
            end
            r.error_code = first_error;
            entries_left = entries_left - LEFT_W'(1);
            byte_pos     = byte_pos + 32'd2;
            if (entries_left == '0) begin
                in_entries    = 1'b0;
                param_pending = 1'b0;
                r.block_last  = 1'b1;
                close_block(r);
            end else begin
                r.last = 1'b1;
                queue_expected(r);
            end
            return;
        end
        if (hdr_index == 2'd0 && dir_exhausted()) begin
            push_end_of_dir();
            return;
        end
        case (hdr_index)
            2'd0: hdr_address = {16'h0000, w};
            2'd1: hdr_address[31:16] = w;
            2'd2: hdr_size = {16'h0000, w};
            default: hdr_size[31:16] = w;
        endcase
        byte_pos = byte_pos + 32'd2;
        if (hdr_index != 2'd3) begin
            hdr_index = hdr_index + 2'd1;
            return;
        end
        hdr_index = 2'd0;
        block_end = {1'b0, byte_pos - HEADER_BYTES} + {1'b0, hdr_size};
        if (hdr_address > image_size_q) begin
            if (first_error == ERR_NONE)
                first_error = ERR_ADDRESS;
            push_end_of_dir();
        end else if (block_end > {1'b0, dir_size_q}) begin
            if (first_error == ERR_NONE)
                first_error = ERR_LENGTH;
            push_end_of_dir();
        end else if (hdr_size >= MIN_BLOCK_BYTES) begin
            entries_left  = LEFT_W'((hdr_size - HEADER_BYTES) >> 1);
            in_entries    = 1'b1;
            param_pending = 1'b0;
        end else begin
            r.kind          = KIND_EMPTY;
            r.block_address = hdr_address;
            r.block_last    = 1'b1;
            r.error_code    = first_error;
            close_block(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatches = mismatches + 1;
    endtask

    task automatic check_result();
        result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing expected, kind", 32'(m_tuser), 32'd0);
            return;
        end
        want = expected_results.pop_front();
        if (m_tuser !== want.kind)
            report_mismatch("kind", 32'(m_tuser), 32'(want.kind));
        if (m_tdata[31:0] !== want.block_address)
            report_mismatch("block_address", m_tdata[31:0], want.block_address);
        if (m_tdata[35:32] !== want.entry_type)
            report_mismatch("entry_type", 32'(m_tdata[35:32]), 32'(want.entry_type));
        if (m_tdata[47:36] !== want.entry_offset)
            report_mismatch("entry_offset", 32'(m_tdata[47:36]), 32'(want.entry_offset));
        if (m_tdata[63:48] !== want.raw_word)
            report_mismatch("raw_word", 32'(m_tdata[63:48]), 32'(want.raw_word));
        if (m_tdata[64] !== want.type_bad)
            report_mismatch("type_bad", 32'(m_tdata[64]), 32'(want.type_bad));
        if (m_tdata[65] !== want.block_last)
            report_mismatch("block_last", 32'(m_tdata[65]), 32'(want.block_last));
        if (m_tdata[67:66] !== want.error_code)
            report_mismatch("error_code", 32'(m_tdata[67:66]), 32'(want.error_code));
        if (m_tdata[71:68] !== 4'h0)
            report_mismatch("tdata padding", 32'(m_tdata[71:68]), 32'd0);
        if (m_tlast !== want.last)
            report_mismatch("last", 32'(m_tlast), 32'(want.last));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parser();
            image_size_q = '0;
            dir_size_q   = '0;
            expected_results.delete();
            mismatches   = 0;
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_DIR_SIZE)
                    dir_size_q = pwdata;
                else
                    image_size_q = pwdata;
            end
            if (s_tvalid && s_tready)
                predict_halfword(s_tdata, s_tuser);
        end
        outstanding = expected_results.size();
    end

endmodule

/* bench/tb_pe_base_relocation_parser_unit.sv */
module tb_pe_base_relocation_parser_unit;
    import pebrp_pkg::*;

    // register byte addresses
    localparam logic [2:0] ADDR_IMAGE_SIZE = 3'h0;
    localparam logic [2:0] ADDR_DIR_SIZE   = 3'h4;

    // items per random phase, 12 phases in all
    localparam int PHASE_ITEMS  = 96;
    localparam int PHASE_COUNT  = 12;
    // settle time after the last expected result, covers items still in flight
    localparam int DRAIN_CYCLES = 8;

    // directed directory: three blocks, the last one closing the directory
    localparam logic [15:0] DIR_BLOCKS [20] = '{
        16'h1000, 16'h0000, 16'h0014, 16'h0000,    // page at image size, 6 entries
        16'h0FFF, 16'hA123, 16'h4ABC, 16'hFFFF,    // highadj with its parameter
        16'hF000, 16'h9001,                        // bad type, then an allowed one
        16'h0000, 16'h0000, 16'h0009, 16'h0000,    // short odd block, empty
        16'h0005, 16'h0000, 16'h000D, 16'h0000,    // odd size, two entries
        16'h5FFF, 16'h4002                         // highadj as final entry
    };

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [2:0]         paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [15:0]        s_tdata  = '0;
    logic               s_tuser  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    int          mismatches;
    int          outstanding;
    int          gap_pct   = 0;     // chance per cycle that the sender holds back
    int          stall_pct = 0;     // chance per cycle that the receiver stalls
    int          words_in_phase;
    logic [31:0] cur_image;         // register values the generator works against
    logic [31:0] cur_dir;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    pe_base_relocation_parser_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    reloc_result_checker result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // receiver backpressure, one decision per cycle
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // setup cycle, access cycle, then idle with psel low so psel never toggles twice in a step
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_sizes(input logic [31:0] image, input logic [31:0] dir);
        cur_image = image;
        cur_dir   = dir;
        write_reg(ADDR_IMAGE_SIZE, image);
        write_reg(ADDR_DIR_SIZE, dir);
    endtask

    // one halfword item, with random sender gaps in front of it
    task automatic send_word(input logic [15:0] w, input logic first_flag);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= first_flag;
        do @(posedge aclk); while (!s_tready);
        words_in_phase = words_in_phase + 1;
    endtask

    // stop sending and wait until every expected result is back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // random directory against the current sizes, cut off after max_words
    task automatic send_directory(input int max_words);
        logic [15:0] words[$];
        longint      pos;
        longint      room;
        longint      size_l;
        longint      n;
        logic [31:0] addr;
        logic [31:0] sz;
        logic [3:0]  ty;
        int          r;
        pos = 0;
        while (words.size() < max_words && pos + 8 < cur_dir) begin
            // page address: mostly inside the image, sometimes at or beyond its end
            r = $urandom_range(15);
            if (r == 0 && cur_image != '1) begin
                addr = $urandom;
                if (addr <= cur_image)
                    addr = cur_image + 32'd1;
            end else if (r == 1)
                addr = cur_image;
            else if (r == 2)
                addr = '0;
            else if (cur_image == '1)
                addr = $urandom;
            else
                addr = $urandom_range(cur_image, 0);
            // block size: short, past the end, exact fit or a handful of entries
            room = cur_dir - pos;
            r    = $urandom_range(99);
            if (r < 10)
                size_l = longint'($urandom_range(9));
            else if (r < 16) begin
                size_l = room + longint'($urandom_range(3, 1));
                if (size_l > 64'hFFFF_FFFF)
                    size_l = 64'hFFFF_FFFF;
            end else if (r < 19)
                size_l = room;
            else begin
                size_l = 8 + 2 * longint'($urandom_range(14, 1))
                         + longint'($urandom_range(3) == 0);
                if (size_l > room)
                    size_l = room;
            end
            sz = size_l[31:0];
            words = {words, addr[15:0]};
            words = {words, addr[31:16]};
            words = {words, sz[15:0]};
            words = {words, sz[31:16]};
            // header error ends the directory
            if (addr > cur_image || pos + sz > cur_dir)
                break;
            if (sz < MIN_BLOCK_BYTES) begin
                pos = pos + 8;
                continue;
            end
            n = longint'((sz - 32'd8) >> 1);
            for (longint i = 0; i < n && words.size() < max_words; i++) begin
                // entry types weighted toward highadj and the bad set
                r = $urandom_range(99);
                if (r < 18)
                    ty = TYPE_HIGHADJ;
                else if (r < 28)
                    ty = $urandom_range(1) ? 4'($urandom_range(8, 6))
                                           : 4'($urandom_range(15, 11));
                else
                    ty = 4'($urandom_range(15));
                words = {words, ty, 12'($urandom)};
            end
            pos = pos + 8 + 2 * n;
        end
        // a few trailing words, ignored once the parser has stopped
        repeat ($urandom_range(2))
            words = {words, 16'($urandom)};
        if (words.size() == 0)
            words = {words, 16'($urandom)};
        foreach (words[k])
            send_word(words[k], k == 0);
    endtask

    initial begin
        int r;
        int count;
        int span;
        int room_left;
        logic [31:0] image;
        logic [31:0] dir;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part: entry fields at their extremes, highadj with and without
        // a parameter, bad type, short and odd blocks, end of directory, then the
        // two header errors; words sent after the end and the address error are ignored
        program_sizes(32'h0000_1000, 32'd48);
        words_in_phase = 0;
        foreach (DIR_BLOCKS[i])
            send_word(DIR_BLOCKS[i], i == 0);
        send_word(16'hBEEF, 1'b0);
        send_word(16'h1001, 1'b1);         // page beyond image
        send_word(16'h0000, 1'b0);
        send_word(16'h000A, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h1234, 1'b0);
        send_word(16'h0000, 1'b1);         // block runs past the directory end
        send_word(16'h0000, 1'b0);
        send_word(16'h0031, 1'b0);
        send_word(16'h0000, 1'b0);
        wait_idle();

        // random part: four idling modes, three size settings each
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p / 3)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 64; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 64; end
                default: begin gap_pct = 35; stall_pct = 35; end
            endcase
            case (p % 4)
                0: begin image = '1; dir = $urandom_range(400, 24); end
                1: begin image = '0; dir = '1; end
                2: begin image = $urandom; dir = $urandom_range(12, 0); end
                default: begin
                    image = $urandom_range(32'h0010_0000, 1);
                    dir   = $urandom_range(600, 16);
                end
            endcase
            if (p == 7)
                dir = '0;
            if (p == 9) begin
                image = '1;
                dir   = '1;
            end
            program_sizes(image, dir);
            words_in_phase = 0;
            while (words_in_phase < PHASE_ITEMS) begin
                // keep each phase close to its item budget
                room_left = PHASE_ITEMS - words_in_phase;
                r = $urandom_range(99);
                if (r < 8) begin
                    // noise: random words, first flag now and then mid-stream
                    count = $urandom_range(20, 1);
                    if (count > room_left)
                        count = room_left;
                    for (int i = 0; i < count; i++)
                        send_word(16'($urandom),
                                  (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(15) == 0));
                end else if (r < 18) begin
                    span = $urandom_range(12, 1);                // cut short, often mid-header
                    send_directory((span < room_left) ? span : room_left);
                end else begin
                    span = $urandom_range(80, 20);
                    send_directory((span < room_left) ? span : room_left);
                end
                // now and then hold off until the result stream is empty
                if ($urandom_range(15) == 0)
                    wait_idle();
            end
            wait_idle();
        end

        wait_idle();
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // hard stop, far beyond the slowest correct run
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
